### sv/wwa_pkg.sv
// Shared types and constants for the weighted window average block.
`timescale 1ns / 1ps

package wwa_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 2;
   localparam int KDIM       = 2 * MAX_RADIUS + 1;
   localparam int KDEPTH     = KDIM * KDIM;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int ADDR_W  = ROW_W + COL_W;
   localparam int KIDX_W  = $clog2(KDEPTH);
   localparam int SIZE_W  = 9;
   localparam int RAD_W   = 2;
   localparam int PIX_W   = 8;
   localparam int WGT_W   = 16;
   localparam int WIDX_W  = 5;
   localparam int CSR_W   = 9;
   localparam int CSRI_W  = 2;

   // window offset, position, product and sums
   localparam int OFS_W   = 3;
   localparam int POS_W   = 10;
   localparam int PROD_W  = WGT_W + PIX_W + 1;
   localparam int ACC_W   = 29;
   localparam int WSUM_W  = 21;
   localparam int NUM_W   = ACC_W - 1;
   localparam int DEN_W   = WSUM_W - 1;
   localparam int QBITS   = PIX_W;
   localparam int QCNT_W  = $clog2(QBITS);

   localparam int REQ_DATA_W = 48;

   typedef enum logic [1:0] {
      REQ_WRITE_PIXEL  = 2'd0,
      REQ_WRITE_WEIGHT = 2'd1,
      REQ_QUERY        = 2'd2,
      REQ_NONE         = 2'd3
   } req_kind_type;

   typedef enum logic [CSRI_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_HALF_WIDTH   = 2'd2,
      CSR_HALF_HEIGHT  = 2'd3
   } csr_index_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCAN  = 7'b0000010,
      ST_DRAIN = 7'b0000100,
      ST_ABS   = 7'b0001000,
      ST_RANGE = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

### sv/weighted_window_average.sv
// Weighted window average: frame store, weight table and query sequencer.
`timescale 1ns / 1ps

// Usage:
//  req channel: tuser carries the request kind (write pixel, write weight, query);
//  tdata carries row, col, pixel_value, weight_index and weight_value.
//  Pixel and weight writes give no rsp word.
//  A query walks the window one position a cycle through a single shared
//  multiply-accumulate, reading the frame store and the weight table at one
//  port each; after a drain step, a sign/magnitude step and a range
//  check, a restoring divider yields one quotient bit a cycle.
//  A query scans (2*hh+1)*(2*hw+1) window positions, up to 25;
//  req_tready is low while the query runs.
//  rsp channel: tdata is filtered_pixel, tuser is zero_sum. The result sits in
//  an output register; the block goes back to taking words while it waits.
//  A later query holds in its last step until the previous word is taken.
//  csr port: csr_we writes register csr_index with csr_wdata; write only
//  while the block is idle.
//  Reset clears control state and loads the register defaults. The frame
//  store and weight table are not cleared and must be written before use.
module weighted_window_average
   import wwa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // row[7:0], col[15:8], pixel_value[23:16], weight_index[28:24],
   // weight_value[44:29], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // filtered_pixel[7:0]
   output logic [PIX_W-1:0]      rsp_tdata,
   // zero_sum
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSRI_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   // request fields
   logic [ROW_W-1:0]        f_row;
   logic [COL_W-1:0]        f_col;
   logic [PIX_W-1:0]        f_pix;
   logic [WIDX_W-1:0]       f_widx;
   logic [WGT_W-1:0]        f_wval;
   req_kind_type            f_kind;
   logic                    req_acc;

   assign f_row  = req_tdata[7:0];
   assign f_col  = req_tdata[15:8];
   assign f_pix  = req_tdata[23:16];
   assign f_widx = req_tdata[28:24];
   assign f_wval = req_tdata[44:29];
   assign f_kind = req_kind_type'(req_tuser);

   // configuration registers
   logic [SIZE_W-1:0] img_w_ff, img_h_ff;
   logic [RAD_W-1:0]  half_w_ff, half_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= SIZE_W'(MAX_WIDTH);
         img_h_ff  <= SIZE_W'(MAX_HEIGHT);
         half_w_ff <= RAD_W'(1);
         half_h_ff <= RAD_W'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  img_w_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: img_h_ff  <= csr_wdata;
            CSR_HALF_WIDTH:   half_w_ff <= csr_wdata[RAD_W-1:0];
            CSR_HALF_HEIGHT:  half_h_ff <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // saturated geometry
   logic [SIZE_W-1:0] lim_w, lim_h;
   logic [RAD_W-1:0]  rad_w, rad_h;

   assign lim_w = (img_w_ff > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : img_w_ff;
   assign lim_h = (img_h_ff > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : img_h_ff;
   assign rad_w = (half_w_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : half_w_ff;
   assign rad_h = (half_h_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : half_h_ff;

   // sequencer state
   state_type                state_ff, state_in;
   logic [ROW_W-1:0]         row_ff;
   logic [COL_W-1:0]         col_ff;
   logic [RAD_W-1:0]         hw_ff, hh_ff;
   logic signed [OFS_W-1:0]  dr_ff, dc_ff;
   logic [KIDX_W-1:0]        k_ff;
   logic                     mac_en_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [WSUM_W-1:0] wsum_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [NUM_W-1:0]         dsh_ff;
   logic [QBITS-1:0]         quo_ff;
   logic [QCNT_W-1:0]        qcnt_ff;
   logic                     zsum_ff;
   logic                     zero_q_ff;
   logic                     rsp_valid_ff;
   logic [PIX_W-1:0]         rsp_pix_ff;
   logic                     rsp_zero_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tuser  = rsp_zero_ff;

   // window position for the current scan step
   logic signed [POS_W-1:0] pos_r, pos_c;
   logic                    in_image;
   logic [ADDR_W-1:0]       rd_addr;
   logic signed [OFS_W-1:0] hw_s, hh_s;
   logic                    last_col, last_row;

   assign hw_s     = $signed({1'b0, hw_ff});
   assign hh_s     = $signed({1'b0, hh_ff});
   assign pos_r    = $signed({2'b00, row_ff}) + POS_W'(dr_ff);
   assign pos_c    = $signed({2'b00, col_ff}) + POS_W'(dc_ff);
   assign in_image = !pos_r[POS_W-1] && (pos_r[SIZE_W-1:0] < lim_h)
                  && !pos_c[POS_W-1] && (pos_c[SIZE_W-1:0] < lim_w);
   assign rd_addr  = {pos_r[ROW_W-1:0], pos_c[COL_W-1:0]};
   assign last_col = (dc_ff == hw_s);
   assign last_row = (dr_ff == hh_s);

   // frame store and weight table, one write port and one read port each
   logic [PIX_W-1:0]        frame_mem [MAX_WIDTH*MAX_HEIGHT];
   logic [WGT_W-1:0]        weight_mem [KDEPTH];
   logic [PIX_W-1:0]        pix_rd_ff;
   logic [WGT_W-1:0]        wgt_rd_ff;

   always_ff @(posedge clock) begin
      if (req_acc && f_kind == REQ_WRITE_PIXEL) begin
         frame_mem[{f_row, f_col}] <= f_pix;
      end
      pix_rd_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (req_acc && f_kind == REQ_WRITE_WEIGHT && f_widx < WIDX_W'(KDEPTH)) begin
         weight_mem[f_widx[KIDX_W-1:0]] <= f_wval;
      end
      wgt_rd_ff <= weight_mem[k_ff];
   end

   // shared multiply-accumulate
   logic signed [PROD_W-1:0] prod;

   assign prod = $signed(wgt_rd_ff) * $signed({1'b0, pix_rd_ff});

   // divider step
   logic             ge_step;
   logic             over;

   assign ge_step = (num_ff >= dsh_ff);
   assign over    = ({1'b0, num_ff} >= {1'b0, den_ff, {QBITS{1'b0}}});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc && f_kind == REQ_QUERY) state_in = ST_SCAN;
         ST_SCAN:  if (last_col && last_row) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_ABS;
         ST_ABS:   state_in = ST_RANGE;
         ST_RANGE: state_in = zero_q_ff ? ST_DONE : (over ? ST_DONE : ST_DIV);
         ST_DIV:   if (qcnt_ff == '0) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mac_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mac_en_ff <= (state_ff == ST_SCAN) && in_image;
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            row_ff  <= f_row;
            col_ff  <= f_col;
            hw_ff   <= rad_w;
            hh_ff   <= rad_h;
            dr_ff   <= -$signed({1'b0, rad_h});
            dc_ff   <= -$signed({1'b0, rad_w});
            k_ff    <= '0;
            acc_ff  <= '0;
            wsum_ff <= '0;
         end
         ST_SCAN: begin
            k_ff <= k_ff + KIDX_W'(1);
            if (last_col) begin
               dc_ff <= -hw_s;
               dr_ff <= dr_ff + OFS_W'(1);
            end else begin
               dc_ff <= dc_ff + OFS_W'(1);
            end
         end
         ST_ABS: begin
            // magnitudes; a sign mismatch, zero numerator or zero weight sum truncates to zero
            num_ff    <= acc_ff[ACC_W-1] ? NUM_W'(-acc_ff) : acc_ff[NUM_W-1:0];
            den_ff    <= wsum_ff[WSUM_W-1] ? DEN_W'(-wsum_ff) : wsum_ff[DEN_W-1:0];
            zsum_ff   <= (wsum_ff == '0);
            zero_q_ff <= (wsum_ff == '0) || (acc_ff == '0)
                      || (acc_ff[ACC_W-1] != wsum_ff[WSUM_W-1]);
         end
         ST_RANGE: begin
            dsh_ff  <= NUM_W'({den_ff, {(QBITS-1){1'b0}}});
            qcnt_ff <= QCNT_W'(QBITS-1);
            if (zero_q_ff) begin
               quo_ff <= '0;
            end else begin
               quo_ff <= '1;
            end
         end
         ST_DIV: begin
            if (ge_step) begin
               num_ff <= num_ff - dsh_ff;
            end
            quo_ff  <= {quo_ff[QBITS-2:0], ge_step};
            dsh_ff  <= dsh_ff >> 1;
            qcnt_ff <= qcnt_ff - QCNT_W'(1);
         end
         default: ;
      endcase

      // accumulate in the cycle after the read
      if (mac_en_ff) begin
         acc_ff  <= acc_ff + ACC_W'(prod);
         wsum_ff <= wsum_ff + WSUM_W'($signed(wgt_rd_ff));
      end

      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_pix_ff  <= quo_ff;
         rsp_zero_ff <= zsum_ff;
      end
   end

endmodule
